// ===== design/ntc_pkg.sv =====
package ntc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FS        = (1 << ADC_BITS) - 1;
    localparam int LOW_MAX   = (FS - 1) / 3300;
    localparam int IN_W      = 16;
    localparam int K_W       = 4;
    localparam int FRAC_W    = 30;
    localparam int LOG_W     = K_W + FRAC_W;
    localparam int M_W       = FRAC_W + 1;
    localparam int BETA_W    = 14;
    localparam int TEMP_W    = 12;
    localparam int HALF_W    = 17;
    localparam int LN2_W     = 28;
    localparam int PH_W      = HALF_W + LN2_W;
    localparam int P_W       = 47;
    localparam int NB_W      = 30;
    localparam int D_W       = 50;
    localparam int DD_W      = 51;
    localparam int N_W       = 60;
    localparam int R_W       = 63;
    localparam int Q_W       = 13;

    localparam logic [BETA_W-1:0] BETA_RESET = 14'd3950;
    localparam logic [LN2_W-1:0]  LN2_Q28    = 28'd186065279;
    localparam logic [12:0]       TNOM_X20   = 13'd5963;
    localparam logic [15:0]       NUM_K      = 16'd59630;
    localparam logic [4:0]        B20_K      = 5'd20;
    localparam logic [Q_W-1:0]    OFFSET     = 13'd2731;
    localparam logic [Q_W-1:0]    Q_HIGH     = 13'd4731;
    localparam logic signed [TEMP_W-1:0] T_LOW     = -12'sd1000;
    localparam logic signed [TEMP_W-1:0] T_HIGH    = 12'sd2000;
    localparam logic signed [TEMP_W-1:0] T_LOWCODE = 12'sd1000;

    typedef struct packed {
        logic              lowf;
        logic              fullf;
        logic [BETA_W-1:0] beta;
    } side_t;

    typedef struct packed {
        side_t          side;
        logic           nonpos;
        logic           ovf;
        logic [D_W-1:0] d;
    } div_ctl_t;

endpackage

// ===== design/ntc_adc_to_temperature.sv =====
// Throughput: one sample per cycle, except while the output is back-pressured
// with the last stage full; set by the fully pipelined log2 squaring chains
// (30 stages), the ln/denominator stages and the 13-step divider.
// Reset (aresetn low, synchronous): pipeline emptied, beta back to 3950.
// The pipeline keeps accepting while a result waits, until its last stage fills.
module ntc_adc_to_temperature
    import ntc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BETA_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] adc_code
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [11:0] temp_deci_c, zero above
    output logic [1:0]        m_tuser    // [0] low_input_flag, [1] saturated_flag
);

    localparam int SQ_N = FRAC_W;

    logic [BETA_W-1:0] beta_reg;
    logic              en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= BETA_RESET;
        end else if (cfg_valid) begin
            beta_reg <= cfg_data;
        end
    end

    // ---------------- stage 0: clamp, special cases, normalize
    logic [IN_W-1:0] x_c, na, nb;
    logic [K_W-1:0]  ka_c, kb_c;
    logic [M_W-1:0]  ma_c, mb_c;
    logic [IN_W+M_W-1:0] sha, shb;

    always_comb begin
        x_c = (s_tdata > IN_W'(FS)) ? IN_W'(FS) : s_tdata;
        na = (x_c == '0) ? IN_W'(1) : x_c;
        nb = IN_W'(FS) - x_c;
        if (nb == '0) nb = IN_W'(1);
        ka_c = '0;
        kb_c = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (na[i]) ka_c = K_W'(i);
            if (nb[i]) kb_c = K_W'(i);
        end
        sha = {{M_W{1'b0}}, na} << (FRAC_W - int'(ka_c));
        shb = {{M_W{1'b0}}, nb} << (FRAC_W - int'(kb_c));
        ma_c = sha[M_W-1:0];
        mb_c = shb[M_W-1:0];
    end

    logic              sq_v_reg  [0:SQ_N];
    side_t             sq_s_reg  [0:SQ_N];
    logic [K_W-1:0]    sq_ka_reg [0:SQ_N];
    logic [K_W-1:0]    sq_kb_reg [0:SQ_N];
    logic [M_W-1:0]    sq_ma_reg [0:SQ_N];
    logic [M_W-1:0]    sq_mb_reg [0:SQ_N];
    logic [FRAC_W-1:0] sq_fa_reg [0:SQ_N];
    logic [FRAC_W-1:0] sq_fb_reg [0:SQ_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_s_reg[0].lowf  <= (x_c <= IN_W'(LOW_MAX));
            sq_s_reg[0].fullf <= (x_c >= IN_W'(FS));
            sq_s_reg[0].beta  <= beta_reg;
            sq_ka_reg[0] <= ka_c;
            sq_kb_reg[0] <= kb_c;
            sq_ma_reg[0] <= ma_c;
            sq_mb_reg[0] <= mb_c;
            sq_fa_reg[0] <= '0;
            sq_fb_reg[0] <= '0;
        end
    end

    // ---------------- squaring chains, one fraction bit per stage
    for (genvar j = 1; j <= SQ_N; j++) begin : g_sq
        logic [2*M_W-1:0] pa, pb;
        logic [M_W:0]     ta, tb;

        always_comb begin
            pa = sq_ma_reg[j-1] * sq_ma_reg[j-1];
            pb = sq_mb_reg[j-1] * sq_mb_reg[j-1];
            ta = pa[FRAC_W +: M_W+1];
            tb = pb[FRAC_W +: M_W+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j] <= sq_v_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_s_reg[j]  <= sq_s_reg[j-1];
                sq_ka_reg[j] <= sq_ka_reg[j-1];
                sq_kb_reg[j] <= sq_kb_reg[j-1];
                sq_ma_reg[j] <= ta[M_W] ? ta[M_W:1] : ta[M_W-1:0];
                sq_mb_reg[j] <= tb[M_W] ? tb[M_W:1] : tb[M_W-1:0];
                sq_fa_reg[j] <= {sq_fa_reg[j-1][FRAC_W-2:0], ta[M_W]};
                sq_fb_reg[j] <= {sq_fb_reg[j-1][FRAC_W-2:0], tb[M_W]};
            end
        end
    end

    // ---------------- E1: log difference magnitude
    logic [LOG_W-1:0] la, lb;
    assign la = {sq_ka_reg[SQ_N], sq_fa_reg[SQ_N]};
    assign lb = {sq_kb_reg[SQ_N], sq_fb_reg[SQ_N]};

    logic             e1_v_reg;
    side_t            e1_s_reg;
    logic             e1_neg_reg;
    logic [LOG_W-1:0] e1_mag_reg;

    // ---------------- E2: split product by ln 2
    logic             e2_v_reg;
    side_t            e2_s_reg;
    logic             e2_neg_reg;
    logic [PH_W-1:0]  e2_ph_reg, e2_pl_reg;

    // ---------------- E3: ln magnitude Q30
    logic             e3_v_reg;
    side_t            e3_s_reg;
    logic             e3_neg_reg;
    logic [LOG_W-1:0] e3_ln_reg;
    logic [PH_W+HALF_W:0] lnsum;

    assign lnsum = ({{(HALF_W+1){1'b0}}, e2_ph_reg} << HALF_W)
                 + {{(HALF_W+1){1'b0}}, e2_pl_reg};

    // ---------------- E4: 5963*ln and numerator scale
    logic             e4_v_reg;
    side_t            e4_s_reg;
    logic             e4_neg_reg;
    logic [P_W-1:0]   e4_p_reg;
    logic [NB_W-1:0]  e4_nb_reg;

    // ---------------- E5: denominator
    logic             e5_v_reg;
    div_ctl_t         e5_c_reg;
    logic [N_W-1:0]   e5_n_reg;
    logic signed [DD_W-1:0] dd_c;
    logic [DD_W-1:0]  b20_c;

    always_comb begin
        b20_c = DD_W'(B20_K * e4_s_reg.beta) << FRAC_W;
        dd_c  = e4_neg_reg ? $signed(b20_c) - $signed(DD_W'(e4_p_reg))
                           : $signed(b20_c) + $signed(DD_W'(e4_p_reg));
    end

    // ---------------- E6: quotient range check
    logic             e6_v_reg;
    div_ctl_t         e6_c_reg;
    div_ctl_t         e6_c_next;
    logic [N_W-1:0]   e6_n_reg;

    // quotient does not fit in Q_W bits when n >= d * 2^Q_W
    always_comb begin
        e6_c_next     = e5_c_reg;
        e6_c_next.ovf = ({3'b0, e5_n_reg} >= {e5_c_reg.d, 13'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
            e4_v_reg <= 1'b0;
            e5_v_reg <= 1'b0;
            e6_v_reg <= 1'b0;
        end else if (en) begin
            e1_v_reg <= sq_v_reg[SQ_N];
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
            e4_v_reg <= e3_v_reg;
            e5_v_reg <= e4_v_reg;
            e6_v_reg <= e5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_s_reg   <= sq_s_reg[SQ_N];
            e1_neg_reg <= (la < lb);
            e1_mag_reg <= (la >= lb) ? la - lb : lb - la;

            e2_s_reg   <= e1_s_reg;
            e2_neg_reg <= e1_neg_reg;
            e2_ph_reg  <= e1_mag_reg[LOG_W-1:HALF_W] * LN2_Q28;
            e2_pl_reg  <= e1_mag_reg[HALF_W-1:0] * LN2_Q28;

            e3_s_reg   <= e2_s_reg;
            e3_neg_reg <= e2_neg_reg;
            e3_ln_reg  <= lnsum[LN2_W +: LOG_W];

            e4_s_reg   <= e3_s_reg;
            e4_neg_reg <= e3_neg_reg;
            e4_p_reg   <= e3_ln_reg * TNOM_X20;
            e4_nb_reg  <= e3_s_reg.beta * NUM_K;

            e5_c_reg.side   <= e4_s_reg;
            e5_c_reg.nonpos <= (dd_c <= 0);
            e5_c_reg.ovf    <= 1'b0;
            e5_c_reg.d      <= dd_c[D_W-1:0];
            e5_n_reg        <= {e4_nb_reg, {FRAC_W{1'b0}}};

            e6_c_reg <= e6_c_next;
            e6_n_reg <= e5_n_reg;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage
    logic           dv_v_reg [0:Q_W];
    div_ctl_t       dv_c_reg [0:Q_W];
    logic [R_W-1:0] dv_r_reg [0:Q_W];
    logic [Q_W-1:0] dv_q_reg [0:Q_W];

    assign dv_v_reg[0] = e6_v_reg;
    assign dv_c_reg[0] = e6_c_reg;
    assign dv_r_reg[0] = R_W'(e6_n_reg);
    assign dv_q_reg[0] = '0;

    for (genvar i = 1; i <= Q_W; i++) begin : g_div
        logic [R_W-1:0] trial;
        logic           ge;

        always_comb begin
            trial = R_W'(dv_c_reg[i-1].d) << (Q_W - i);
            ge    = (dv_r_reg[i-1] >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[i] <= 1'b0;
            end else if (en) begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_c_reg[i] <= dv_c_reg[i-1];
                dv_r_reg[i] <= ge ? dv_r_reg[i-1] - trial : dv_r_reg[i-1];
                dv_q_reg[i] <= {dv_q_reg[i-1][Q_W-2:0], ge};
            end
        end
    end

    // ---------------- result selection and output register
    div_ctl_t               fc;
    logic [Q_W-1:0]         q;
    logic signed [Q_W+1:0]  v;
    logic signed [TEMP_W-1:0] temp_c;
    logic                   low_c, sat_c;

    always_comb begin
        fc     = dv_c_reg[Q_W];
        q      = dv_q_reg[Q_W];
        v      = $signed({2'b00, q}) - $signed({2'b00, OFFSET})
               + ((q < OFFSET && dv_r_reg[Q_W] != '0) ? 15'sd1 : 15'sd0);
        temp_c = T_LOW;
        low_c  = 1'b0;
        sat_c  = 1'b1;
        if (fc.side.lowf) begin
            temp_c = T_LOWCODE;
            low_c  = 1'b1;
            sat_c  = 1'b0;
        end else if (fc.side.fullf || fc.nonpos) begin
            temp_c = T_LOW;
        end else if (fc.ovf || q > Q_HIGH) begin
            temp_c = T_HIGH;
        end else if (v < $signed({{(Q_W+2-TEMP_W){T_LOW[TEMP_W-1]}}, T_LOW})) begin
            temp_c = T_LOW;
        end else begin
            temp_c = v[TEMP_W-1:0];
            sat_c  = 1'b0;
        end
    end

    logic               out_v_reg;
    logic [TEMP_W-1:0]  out_t_reg;
    logic [1:0]         out_u_reg;
    logic               out_load;

    assign out_load = !out_v_reg || m_tready;
    assign en       = !(dv_v_reg[Q_W] && !out_load);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= dv_v_reg[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_t_reg <= temp_c;
            out_u_reg <= {sat_c, low_c};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(16-TEMP_W){1'b0}}, out_t_reg};
    assign m_tuser  = out_u_reg;

`ifndef SYNTHESIS
    a_low_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[11:0] == 12'd1000 && !m_tuser[1])
        else $error("low input result wrong");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[11:0] == 12'hC18 || m_tdata[11:0] == 12'd2000)
        else $error("saturated value wrong");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");
`endif

endmodule

// ===== sim/ntc_adc_to_temperature_tb.sv =====
`timescale 1ns / 1ps

module ntc_adc_to_temperature_tb;
    import ntc_pkg::*;

    typedef struct packed {
        logic signed [11:0] temp;
        logic               lowf;
        logic               satf;
    } temp_res_t;

    typedef struct {
        logic [15:0] code;
        logic        known;
        temp_res_t   res;
    } vec_t;

    localparam int LATENCY   = 50;
    localparam int N_RANDOM  = 750;
    localparam int MAX_CYC   = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BETA_W-1:0] cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic [1:0]        m_tuser;

    temp_res_t   temp_q[$];
    int          n_err = 0;
    int          cyc = 0;
    bit          quiet = 1'b0;
    logic [13:0] beta_cur = 14'd3950;

    ntc_adc_to_temperature u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [33:0] log2_fix(input logic [15:0] n);
        logic [3:0]  k;
        logic [63:0] m;
        logic [29:0] f;
        k = 0;
        f = 0;
        if (n == 0) n = 1;
        for (int i = 0; i < 16; i++) if (n[i]) k = 4'(i);
        m = 64'(n) << (30 - k);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                f[0] = 1'b1;
            end
        end
        return {k, f};
    endfunction

    function automatic temp_res_t predict_temp(input logic [15:0] code,
                                               input logic [13:0] beta);
        logic [15:0]  x;
        logic [63:0]  la, lb, mag, lnq, n, d, q, r;
        logic signed [63:0] lq, dd, v;
        temp_res_t    o;
        x = (code > FS) ? 16'(FS) : code;
        o = '{temp: 0, lowf: 0, satf: 1};
        if (64'(x) * 3300 < 64'(FS)) return '{temp: T_LOWCODE, lowf: 1, satf: 0};
        if (x >= FS) return '{temp: T_LOW, lowf: 0, satf: 1};
        la = 64'(log2_fix(x));
        lb = 64'(log2_fix(16'(FS) - x));
        mag = (la >= lb) ? la - lb : lb - la;
        lnq = (mag * 64'd186065279) >> 28;
        lq = (la >= lb) ? $signed(lnq) : -$signed(lnq);
        dd = $signed(64'd20 * beta * (64'd1 << 30)) + 64'sd5963 * lq;
        if (dd <= 0) return '{temp: T_LOW, lowf: 0, satf: 1};
        d = dd;
        n = 64'd59630 * beta * (64'd1 << 30);
        q = n / d;
        r = n % d;
        if (q >= 2731) begin
            if (q > 4731) return '{temp: T_HIGH, lowf: 0, satf: 1};
            v = $signed(q) - 2731;
        end else begin
            v = $signed(q) + (r != 0 ? 1 : 0) - 2731;
        end
        if (v < -1000) o.temp = T_LOW;
        else if (v > 2000) o.temp = T_HIGH;
        else begin
            o.temp = v[11:0];
            o.satf = 1'b0;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
        n_err++;
    endtask

    task automatic idle_gap();
        while (!quiet && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic send_code(input logic [15:0] code, input logic known,
                             input temp_res_t want);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        temp_q.push_back(known ? want : predict_temp(code, beta_cur));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (temp_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_beta(input logic [13:0] b);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        beta_cur = b;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        temp_res_t got, want;
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("Mismatches found");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{temp: m_tdata[11:0], lowf: m_tuser[0], satf: m_tuser[1]};
            if (temp_q.size() == 0) begin
                report_mismatch("unexpected request", got.temp, 0);
            end else begin
                want = temp_q.pop_front();
                if (got.temp !== want.temp) report_mismatch("temp", got.temp, want.temp);
                if (got.lowf !== want.lowf) report_mismatch("low flag", got.lowf, want.lowf);
                if (got.satf !== want.satf) report_mismatch("sat flag", got.satf, want.satf);
                if (m_tdata[15:12] !== 4'd0) report_mismatch("pad", m_tdata[15:12], 0);
            end
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    initial begin
        vec_t dir[$];
        logic [13:0] betas[6];
        logic [15:0] c;
        temp_res_t none;
        none = '0;
        dir.push_back('{16'd0,     1, '{T_LOWCODE, 1, 0}});
        dir.push_back('{16'd1,     1, '{T_LOWCODE, 1, 0}});
        dir.push_back('{16'd2,     0, none});
        dir.push_back('{16'd3,     0, none});
        dir.push_back('{16'd2047,  0, none});
        dir.push_back('{16'd2048,  0, none});
        dir.push_back('{16'd4094,  0, none});
        dir.push_back('{16'd4095,  1, '{T_LOW, 0, 1}});
        dir.push_back('{16'd4096,  1, '{T_LOW, 0, 1}});
        dir.push_back('{16'hFFFF,  1, '{T_LOW, 0, 1}});
        dir.push_back('{16'hAAAA,  1, '{T_LOW, 0, 1}});
        dir.push_back('{16'h5555,  1, '{T_LOW, 0, 1}});
        dir.push_back('{16'd100,   0, none});
        dir.push_back('{16'd3900,  0, none});
        dir.push_back('{16'd500,   0, none});
        dir.push_back('{16'd1000,  0, none});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir[i]) send_code(dir[i].code, dir[i].known, dir[i].res);
        // zero beta: denominator/numerator degenerate cases
        write_beta(14'd0);
        foreach (dir[i]) send_code(dir[i].code, 0, none);
        write_beta(14'h3FFF);
        foreach (dir[i]) send_code(dir[i].code, 0, none);

        betas = '{14'd1000, 14'd10000, 14'd3950, 14'd1, 14'h3FFF, 14'd0};
        for (int p = 0; p < 6; p++) begin
            write_beta(p == 5 ? 14'($urandom_range(1000, 10000)) : betas[p]);
            quiet = (p == 2);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                case ($urandom_range(9))
                    0: c = 16'($urandom);
                    1: c = 16'($urandom_range(3));
                    2: c = 16'($urandom_range(4095, 4090));
                    default: c = 16'($urandom_range(4095));
                endcase
                send_code(c, 0, none);
            end
            quiet = 1'b0;
        end
        write_beta(14'd3950);

        drain();
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
